@@ design/rrfsd_pkg.sv @@
// Shared types and constants for the round-robin free-server dispatcher.
package rrfsd_pkg;

  // Field widths.
  localparam int unsigned IDX_W   = 4;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned BUSY_W  = 33;
  localparam int unsigned TOTAL_W = 48;
  localparam int unsigned CNT_W   = 5;

  // Server indexes are four bits wide, so at most this many servers take part.
  localparam int unsigned INDEX_CAP       = 16;
  localparam int unsigned SERVERS_DEFAULT = 16;

  localparam logic [CNT_W-1:0] SERVER_COUNT_RESET = CNT_W'(16);

  // Control states of the sequencer.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DISP,
    ST_MAX,
    ST_LIST
  } state_e;

  // What the cells do with the token this cycle.
  typedef enum logic [1:0] {
    MODE_DISP,
    MODE_MAX,
    MODE_LIST
  } mode_e;

  // Token moving along the chain: its running maximum and tie count.
  typedef struct packed {
    logic               valid;
    logic [TOTAL_W-1:0] max;
    logic [CNT_W-1:0]   cnt;
  } link_t;

  // Values broadcast to every cell.
  typedef struct packed {
    logic              en;
    mode_e             mode;
    logic [TIME_W-1:0] arrival;
    logic [TIME_W-1:0] work;
    logic [BUSY_W-1:0] busy_new;
  } cell_ctrl_t;

  // What one cell reports back.
  typedef struct packed {
    logic  claim;
    logic  listed;
    link_t pass;
  } cell_stat_t;

endpackage

@@ design/rrfsd_cell.sv @@
// One server cell: busy timer, running total and a token slot in the chain.
module rrfsd_cell (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  rrfsd_pkg::cell_ctrl_t  ctrl_i,
  input  rrfsd_pkg::link_t       link_i,
  output rrfsd_pkg::cell_stat_t  stat_o
);
  import rrfsd_pkg::*;

  logic               tok_q, tok_d;
  logic [TOTAL_W-1:0] max_q, max_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [BUSY_W-1:0]  busy_q, busy_d;
  logic [TOTAL_W-1:0] total_q, total_d;
  logic               free;
  logic               claim;
  logic [TOTAL_W:0]   sum;

  // The server is free when its timer ran out strictly before the arrival.
  assign free  = busy_q < {1'b0, ctrl_i.arrival};
  assign claim = tok_q && (ctrl_i.mode == MODE_DISP) && free;
  assign sum   = {1'b0, total_q} + (TOTAL_W + 1)'(ctrl_i.work);

  // Report back and hand the token on to the neighbor.
  always_comb begin
    stat_o.claim      = claim;
    stat_o.listed     = tok_q && (ctrl_i.mode == MODE_LIST) && (total_q == max_q);
    stat_o.pass.valid = tok_q && !claim;
    stat_o.pass.max   = max_q;
    stat_o.pass.cnt   = cnt_q;
    if (ctrl_i.mode == MODE_MAX) begin
      if (total_q > max_q) begin
        stat_o.pass.max = total_q;
        stat_o.pass.cnt = CNT_W'(1);
      end else if (total_q == max_q) begin
        stat_o.pass.cnt = cnt_q + CNT_W'(1);
      end
    end
  end

  // When enabled, the slot takes the link; a claim sets busy and total.
  always_comb begin
    tok_d   = tok_q;
    max_d   = max_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    total_d = total_q;
    if (ctrl_i.en) begin
      tok_d = link_i.valid;
      max_d = link_i.max;
      cnt_d = link_i.cnt;
      if (claim) begin
        busy_d  = ctrl_i.busy_new;
        total_d = sum[TOTAL_W] ? {TOTAL_W{1'b1}} : sum[TOTAL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q   <= 1'b0;
      busy_q  <= '0;
      total_q <= '0;
    end else begin
      tok_q   <= tok_d;
      busy_q  <= busy_d;
      total_q <= total_d;
    end
  end

  // Token payload needs no reset.
  always_ff @(posedge clk_i) begin
    max_q <= max_d;
    cnt_q <= cnt_d;
  end

endmodule

@@ design/round_robin_free_server_dispatch.sv @@
// Round-robin free-server dispatcher: a ring of server cells walked by one token.
//
// One input word is taken at a time. A dispatch word sends a token around the ring of
// server cells from the search start, one cell per cycle while not stalled, and the
// first cell whose busy timer lies strictly below the arrival time claims the request;
// if none of the n active servers claims it, the request is dropped. A report word runs
// the token once over all n cells to find the largest total and its tie count, then
// again from cell 0, emitting one word per tied server until the last one. The token
// stops when a result is due and the full output register is not read. The next input
// word is accepted in the cycle after the last result enters the output register, which
// holds a finished result while the next word starts. Writes to the server count are
// taken at any time and belong only to idle periods.
module round_robin_free_server_dispatch #(
  parameter int unsigned SERVERS = rrfsd_pkg::SERVERS_DEFAULT
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Server count write channel.
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [rrfsd_pkg::CNT_W-1:0]     cfg_server_count_i,
  // Input words.
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            action_i,
  input  logic [rrfsd_pkg::TIME_W-1:0]    arrival_time_i,
  input  logic [rrfsd_pkg::TIME_W-1:0]    work_amount_i,
  // Result words.
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            accepted_o,
  output logic [rrfsd_pkg::IDX_W-1:0]     server_index_o,
  output logic                            last_o
);
  import rrfsd_pkg::*;

  localparam int unsigned CELLS = (SERVERS < INDEX_CAP) ? SERVERS : INDEX_CAP;

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   sc_q, sc_d;
  logic [IDX_W-1:0]   ss_q, ss_d;
  logic [IDX_W-1:0]   steps_q, steps_d;
  logic [CNT_W-1:0]   emitted_q, emitted_d;
  logic [TIME_W-1:0]  t_q, w_q;
  logic               out_valid_q, out_valid_d;
  logic               acc_q, acc_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic               last_q, last_d;

  logic [CNT_W-1:0]   n;
  logic [IDX_W-1:0]   start;
  logic               accept;
  logic               en;
  logic               claim_any;
  logic               listed_any;
  logic [IDX_W-1:0]   hit_idx;
  logic [CNT_W-1:0]   hit_cnt;
  logic               list_last;
  logic               dropped;
  logic               emit_req;
  logic               emit_acc;
  logic               emit_last;
  logic               kill;
  logic [CNT_W:0]     next_ss;
  logic [BUSY_W-1:0]  end_time;
  mode_e              mode;
  link_t              wrap;
  cell_ctrl_t         ctrl;
  link_t              chain [CELLS];
  link_t              link  [CELLS];
  cell_stat_t         stat  [CELLS];

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;

  // Active server count, raised to at least one and clamped to the cells that exist.
  always_comb begin
    n = sc_q;
    if (sc_q == '0) begin
      n = CNT_W'(1);
    end else if (sc_q > CNT_W'(CELLS)) begin
      n = CNT_W'(CELLS);
    end
  end

  assign start = ({1'b0, ss_q} < n) ? ss_q : '0;

  // Shared busy-until value for the claiming cell.
  assign end_time = {1'b0, t_q} + {1'b0, w_q};

  assign ctrl.en       = en;
  assign ctrl.mode     = mode;
  assign ctrl.arrival  = t_q;
  assign ctrl.work     = w_q;
  assign ctrl.busy_new = (end_time == '0) ? '0 : end_time - BUSY_W'(1);

  // Gather the holder's report and the token leaving the last active cell.
  always_comb begin
    claim_any  = 1'b0;
    listed_any = 1'b0;
    hit_idx    = '0;
    hit_cnt    = '0;
    wrap       = '0;
    for (int i = 0; i < CELLS; i++) begin
      claim_any  = claim_any | stat[i].claim;
      listed_any = listed_any | stat[i].listed;
      if (stat[i].claim || stat[i].listed) begin
        hit_idx = hit_idx | IDX_W'(i);
        hit_cnt = hit_cnt | stat[i].pass.cnt;
      end
      if (CNT_W'(i) == n - CNT_W'(1)) begin
        wrap = stat[i].pass;
      end
    end
  end

  assign list_last = (emitted_q + CNT_W'(1)) == hit_cnt;
  assign dropped   = (state_q == ST_DISP) && !claim_any &&
                     ({1'b0, steps_q} == n - CNT_W'(1));

  // Ring wiring: cell 0 is fed from the last active cell.
  for (genvar gi = 0; gi < CELLS; gi++) begin : g_chain
    if (gi == 0) begin : g_head
      assign chain[gi] = wrap;
    end else begin : g_body
      assign chain[gi] = stat[gi-1].pass;
    end
  end

  // Links into the cells: a fresh token on acceptance, else the ring; a kill or an inactive cell clears the token.
  always_comb begin
    for (int i = 0; i < CELLS; i++) begin
      link[i] = chain[i];
      if (accept) begin
        link[i] = '0;
        link[i].valid = action_i ? (i == 0) : (CNT_W'(i) == {1'b0, start});
      end
      link[i].valid = link[i].valid && !kill && (CNT_W'(i) < n);
    end
  end

  for (genvar gi = 0; gi < CELLS; gi++) begin : g_cell
    rrfsd_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl),
      .link_i (link[gi]),
      .stat_o (stat[gi])
    );
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = action_i ? ST_MAX : ST_DISP;
        end
      end
      ST_DISP: begin
        if (en && (claim_any || dropped)) begin
          state_d = ST_IDLE;
        end
      end
      ST_MAX: begin
        if (wrap.valid) begin
          state_d = ST_LIST;
        end
      end
      ST_LIST: begin
        if (en && listed_any && list_last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs: cell mode, result request and token kill.
  always_comb begin
    mode      = MODE_DISP;
    emit_req  = 1'b0;
    emit_acc  = 1'b1;
    emit_last = 1'b1;
    kill      = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        mode = MODE_DISP;
      end
      ST_DISP: begin
        mode     = MODE_DISP;
        emit_req = claim_any || dropped;
        emit_acc = claim_any;
        kill     = dropped;
      end
      ST_MAX: begin
        mode = MODE_MAX;
      end
      ST_LIST: begin
        mode      = MODE_LIST;
        emit_req  = listed_any;
        emit_last = list_last;
        kill      = listed_any && list_last;
      end
      default: mode = MODE_DISP;
    endcase
  end

  // The token waits while a result is due and the output register is full and not being read.
  assign en = !(emit_req && out_valid_q && !out_ready_i);

  // Search start, counters and configuration.
  assign next_ss = {1'b0, hit_idx} + (CNT_W + 1)'(1);

  always_comb begin
    sc_d      = cfg_valid_i ? cfg_server_count_i : sc_q;
    ss_d      = ss_q;
    steps_d   = steps_q;
    emitted_d = emitted_q;
    if (accept) begin
      steps_d   = '0;
      emitted_d = '0;
    end else if (en) begin
      if (state_q == ST_DISP) begin
        steps_d = steps_q + IDX_W'(1);
        if (claim_any) begin
          ss_d = (next_ss >= {1'b0, n}) ? '0 : next_ss[IDX_W-1:0];
        end
      end
      if ((state_q == ST_LIST) && listed_any) begin
        emitted_d = emitted_q + CNT_W'(1);
      end
    end
  end

  // Output register.
  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    acc_d       = acc_q;
    idx_d       = idx_q;
    last_d      = last_q;
    if (emit_req && en) begin
      out_valid_d = 1'b1;
      acc_d       = emit_acc;
      idx_d       = emit_acc ? hit_idx : '0;
      last_d      = emit_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sc_q        <= SERVER_COUNT_RESET;
      ss_q        <= '0;
      steps_q     <= '0;
      emitted_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sc_q        <= sc_d;
      ss_q        <= ss_d;
      steps_q     <= steps_d;
      emitted_q   <= emitted_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Request payload and result fields need no reset.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      t_q <= arrival_time_i;
      w_q <= work_amount_i;
    end
    acc_q  <= acc_d;
    idx_q  <= idx_d;
    last_q <= last_d;
  end

  assign out_valid_o    = out_valid_q;
  assign accepted_o     = acc_q;
  assign server_index_o = idx_q;
  assign last_o         = last_q;

endmodule

@@ design/rrfsd_checker.sv @@
// Port-level checks for the dispatcher, bound to the top level.
module rrfsd_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_o,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic                         accepted_o,
  input logic [rrfsd_pkg::IDX_W-1:0]  server_index_o,
  input logic                         last_o
);
  import rrfsd_pkg::*;

  // A result word waits until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result word dropped before it was taken");

  // A waiting result word keeps its fields.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      $stable(accepted_o) && $stable(server_index_o) && $stable(last_o))
    else $error("waiting result word changed");

  // A dropped request gives server 0 and closes its input word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !accepted_o |-> (server_index_o == '0) && last_o)
    else $error("dropped request with bad index or last flag");

  // One input word at a time: the block is busy right after taking one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while the previous word is still in work");

endmodule

bind round_robin_free_server_dispatch rrfsd_checker u_rrfsd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .accepted_o     (accepted_o),
  .server_index_o (server_index_o),
  .last_o         (last_o)
);
